// ----- rtl/slfd_pkg.sv -----
`default_nettype none

package slfd_pkg;

    localparam int BUFFER_DEPTH = 1024;
    localparam int ADDR_W = $clog2(BUFFER_DEPTH);
    localparam int LEN_W = 11;
    localparam int COUNT_W = 32;

    localparam logic [7:0] SYNC0_BYTE = 8'hA5;
    localparam logic [7:0] SYNC1_BYTE = 8'h5A;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 11'd1024;
    localparam logic [LEN_W-1:0] LEN_SAT = 11'd2047;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 160;

    typedef enum logic [2:0] {
        PH_SYNC0,
        PH_SYNC1,
        PH_LEN0,
        PH_LEN1,
        PH_SEQ,
        PH_PAYLOAD,
        PH_CRC0,
        PH_CRC1
    } phase_t;

    typedef enum logic [1:0] {
        OP_LINK  = 2'd0,
        OP_READ  = 2'd1,
        OP_COUNT = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        KIND_GOOD     = 3'd0,
        KIND_CRC_ERR  = 3'd1,
        KIND_OVERSIZE = 3'd2,
        KIND_READ     = 3'd3,
        KIND_COUNT    = 3'd4
    } kind_t;

    typedef struct packed {
        logic               valid;
        kind_t              kind;
        logic [7:0]         seq;
        logic [LEN_W-1:0]   length;
        logic               read_ok;
        logic [COUNT_W-1:0] good;
        logic [COUNT_W-1:0] crc_err;
        logic [COUNT_W-1:0] discard;
        logic [COUNT_W-1:0] oversize;
    } result_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } buf_wr_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/slfd_buffer.sv -----
`default_nettype none

module slfd_buffer (
    input  wire                          aclk,
    input  wire slfd_pkg::buf_wr_t       wr,
    input  wire                          rd_en,
    input  wire [slfd_pkg::ADDR_W-1:0]   rd_addr,
    output logic [7:0]                   rd_data
);

    logic [7:0] mem [slfd_pkg::BUFFER_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/slfd_framer.sv -----
`default_nettype none

module slfd_framer (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               step_en,
    input  wire [1:0]                         opcode,
    input  wire [7:0]                         data_byte,
    input  wire [slfd_pkg::ADDR_W-1:0]        read_index,
    input  wire [slfd_pkg::LEN_W-1:0]         max_length,
    output slfd_pkg::result_t                 res,
    output slfd_pkg::buf_wr_t                 wr
);

    slfd_pkg::phase_t                phase_reg, phase_next;
    logic [7:0]                      len_low_reg, len_low_next;
    logic [slfd_pkg::LEN_W-1:0]      frame_len_reg, frame_len_next;
    logic [slfd_pkg::LEN_W-1:0]      stored_reg, stored_next;
    logic [7:0]                      seq_reg, seq_next;
    logic [7:0]                      crc_low_reg, crc_low_next;
    logic [15:0]                     crc_reg, crc_next;
    logic [slfd_pkg::COUNT_W-1:0]    good_reg, good_next;
    logic [slfd_pkg::COUNT_W-1:0]    crc_err_reg, crc_err_next;
    logic [slfd_pkg::COUNT_W-1:0]    discard_reg, discard_next;
    logic [slfd_pkg::COUNT_W-1:0]    oversize_reg, oversize_next;

    logic [15:0]                     len16;
    logic [15:0]                     rx_crc;
    logic [15:0]                     crc_upd;
    logic [slfd_pkg::LEN_W-1:0]      stored_inc;

    assign len16 = {data_byte, len_low_reg};
    assign rx_crc = {data_byte, crc_low_reg};
    assign crc_upd = slfd_pkg::crc16_byte(crc_reg, data_byte);
    assign stored_inc = stored_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= slfd_pkg::PH_SYNC0;
            len_low_reg   <= '0;
            frame_len_reg <= '0;
            stored_reg    <= '0;
            seq_reg       <= '0;
            crc_low_reg   <= '0;
            crc_reg       <= slfd_pkg::CRC_INIT;
            good_reg      <= '0;
            crc_err_reg   <= '0;
            discard_reg   <= '0;
            oversize_reg  <= '0;
        end else if (step_en) begin
            phase_reg     <= phase_next;
            len_low_reg   <= len_low_next;
            frame_len_reg <= frame_len_next;
            stored_reg    <= stored_next;
            seq_reg       <= seq_next;
            crc_low_reg   <= crc_low_next;
            crc_reg       <= crc_next;
            good_reg      <= good_next;
            crc_err_reg   <= crc_err_next;
            discard_reg   <= discard_next;
            oversize_reg  <= oversize_next;
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        len_low_next   = len_low_reg;
        frame_len_next = frame_len_reg;
        stored_next    = stored_reg;
        seq_next       = seq_reg;
        crc_low_next   = crc_low_reg;
        crc_next       = crc_reg;
        good_next      = good_reg;
        crc_err_next   = crc_err_reg;
        discard_next   = discard_reg;
        oversize_next  = oversize_reg;
        res            = '0;
        wr             = '0;

        case (opcode)
            slfd_pkg::OP_LINK: begin
                case (phase_reg)
                    slfd_pkg::PH_SYNC0: begin
                        if (data_byte == slfd_pkg::SYNC0_BYTE) begin
                            phase_next = slfd_pkg::PH_SYNC1;
                        end else begin
                            discard_next = discard_reg + 1'b1;
                        end
                    end
                    slfd_pkg::PH_SYNC1: begin
                        if (data_byte == slfd_pkg::SYNC1_BYTE) begin
                            phase_next = slfd_pkg::PH_LEN0;
                        end else begin
                            discard_next = discard_reg + 1'b1;
                            if (data_byte != slfd_pkg::SYNC0_BYTE) begin
                                phase_next = slfd_pkg::PH_SYNC0;
                            end
                        end
                    end
                    slfd_pkg::PH_LEN0: begin
                        len_low_next = data_byte;
                        crc_next = slfd_pkg::crc16_byte(slfd_pkg::CRC_INIT, data_byte);
                        phase_next = slfd_pkg::PH_LEN1;
                    end
                    slfd_pkg::PH_LEN1: begin
                        if (len16 > {5'b0, max_length}) begin
                            oversize_next = oversize_reg + 1'b1;
                            phase_next = slfd_pkg::PH_SYNC0;
                            res.valid = 1'b1;
                            res.kind = slfd_pkg::KIND_OVERSIZE;
                            res.length = (len16 > {5'b0, slfd_pkg::LEN_SAT}) ?
                                         slfd_pkg::LEN_SAT : len16[slfd_pkg::LEN_W-1:0];
                        end else begin
                            frame_len_next = len16[slfd_pkg::LEN_W-1:0];
                            crc_next = crc_upd;
                            phase_next = slfd_pkg::PH_SEQ;
                        end
                    end
                    slfd_pkg::PH_SEQ: begin
                        seq_next = data_byte;
                        stored_next = '0;
                        crc_next = crc_upd;
                        phase_next = (frame_len_reg == '0) ? slfd_pkg::PH_CRC0 :
                                                             slfd_pkg::PH_PAYLOAD;
                    end
                    slfd_pkg::PH_PAYLOAD: begin
                        wr.en = step_en &&
                                (stored_reg < slfd_pkg::LEN_W'(slfd_pkg::BUFFER_DEPTH));
                        wr.addr = stored_reg[slfd_pkg::ADDR_W-1:0];
                        wr.data = data_byte;
                        stored_next = stored_inc;
                        crc_next = crc_upd;
                        if (stored_inc >= frame_len_reg) begin
                            phase_next = slfd_pkg::PH_CRC0;
                        end
                    end
                    slfd_pkg::PH_CRC0: begin
                        crc_low_next = data_byte;
                        phase_next = slfd_pkg::PH_CRC1;
                    end
                    default: begin
                        phase_next = slfd_pkg::PH_SYNC0;
                        res.valid = 1'b1;
                        if (rx_crc == crc_reg) begin
                            good_next = good_reg + 1'b1;
                            res.kind = slfd_pkg::KIND_GOOD;
                        end else begin
                            crc_err_next = crc_err_reg + 1'b1;
                            res.kind = slfd_pkg::KIND_CRC_ERR;
                        end
                        res.seq = seq_reg;
                        res.length = frame_len_reg;
                    end
                endcase
            end
            slfd_pkg::OP_READ: begin
                res.valid = 1'b1;
                res.kind = slfd_pkg::KIND_READ;
                res.read_ok = (slfd_pkg::LEN_W'(read_index) < stored_reg) &&
                              (slfd_pkg::LEN_W'(read_index) <
                               slfd_pkg::LEN_W'(slfd_pkg::BUFFER_DEPTH));
            end
            slfd_pkg::OP_COUNT: begin
                res.valid = 1'b1;
                res.kind = slfd_pkg::KIND_COUNT;
                res.good = good_reg;
                res.crc_err = crc_err_reg;
                res.discard = discard_reg;
                res.oversize = oversize_reg;
            end
            default: begin
                res = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/sync_length_crc16_deframer_core.sv -----
// path: input item held in the input register, its result in the result register
// throughput: one item per cycle unless m_tready stalls; the byte-wide crc update and
// one buffer write per byte fit between the input register and the result register
// reset: aresetn synchronous active low; clears framing state, counters and max_length
// (to 1024); the payload buffer is not cleared
`default_nettype none

module sync_length_crc16_deframer_core (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire [slfd_pkg::S_TDATA_W-1:0]      s_tdata,  // data_byte, read_index
    input  wire [1:0]                          s_tuser,  // opcode
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // packet_seq, packet_length, read_data, good_count, crc_error_count,
    // discard_count, oversize_count
    output logic [slfd_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [2:0]                         m_tuser,  // result_kind
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire [slfd_pkg::LEN_W-1:0]          cfg_data
);

    logic                            in_valid_reg, in_valid_next;
    logic [1:0]                      op_reg;
    logic [7:0]                      byte_reg;
    logic [slfd_pkg::ADDR_W-1:0]     idx_reg;
    logic                            out_valid_reg, out_valid_next;
    slfd_pkg::result_t               out_reg;
    logic [slfd_pkg::LEN_W-1:0]      max_len_reg;

    logic                            s_accept;
    logic                            proceed;
    slfd_pkg::result_t               res;
    slfd_pkg::buf_wr_t               wr;
    logic [7:0]                      rd_data;
    logic [7:0]                      read_byte;

    assign cfg_ready = 1'b1;
    assign proceed = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proceed;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (proceed) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (proceed) begin
            out_valid_next = res.valid;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            max_len_reg   <= slfd_pkg::MAX_LENGTH_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                max_len_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg   <= s_tuser;
            byte_reg <= s_tdata[7:0];
            idx_reg  <= s_tdata[8 +: slfd_pkg::ADDR_W];
        end
        if (proceed) begin
            out_reg <= res;
        end
    end

    slfd_framer u_framer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (proceed),
        .opcode     (op_reg),
        .data_byte  (byte_reg),
        .read_index (idx_reg),
        .max_length (max_len_reg),
        .res        (res),
        .wr         (wr)
    );

    slfd_buffer u_buffer (
        .aclk    (aclk),
        .wr      (wr),
        .rd_en   (proceed && (op_reg == slfd_pkg::OP_READ)),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign read_byte = out_reg.read_ok ? rd_data : 8'h00;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {5'b0, out_reg.oversize, out_reg.discard, out_reg.crc_err,
                       out_reg.good, read_byte, out_reg.length, out_reg.seq};

endmodule

`default_nettype wire
